// ===== rtl/cfr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame table.
package cfr_pkg;

    localparam int SLOT_W  = 4;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int PASSES  = 3;
    localparam int FLAGS_W = 6;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REF     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PIN     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNPIN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PINNED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOUSE  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_FREE_RD,
        S_FREE_EV,
        S_OP_RD,
        S_OP_EV,
        S_SCAN_RD,
        S_SCAN_EV
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_SLOT,
        IDX_HAND,
        IDX_NEXT_HAND
    } t_idx_sel;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_FILL,
        WR_OP,
        WR_AGE
    } t_wr_sel;

    typedef enum logic [2:0] {
        RESP_OK,
        RESP_NOUSE,
        RESP_PINNED,
        RESP_GRANT,
        RESP_EVICT
    } t_resp_sel;

    typedef struct packed {
        logic used;
        logic pinned;
        logic accessed;
        logic dirty;
        logic readonly;
        logic pend;
    } t_flags;

    typedef struct packed {
        logic      latch;
        t_idx_sel  idx_sel;
        logic      scan_init;
        logic      ram_wr;
        t_wr_sel   wr_sel;
        logic      hand_adv;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      resp;
        t_resp_sel resp_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_alloc;
        logic cmd_op;
        logic cmd_release;
        logic slot_ok;
        logic full;
        logic q_used;
        logic suit;
        logic wrap_last;
        logic clear_last;
    } t_dp_stat;

endpackage

// ===== rtl/clock_frame_replacement_core.sv =====
// Top level of the clock second-chance frame replacement table.
//
// An item (command) is taken at a clock edge with start high and busy low. Each
// item gives one result, shown on the o_ result ports for exactly one cycle with
// o_done high; the receiver cannot stall it, so it must sample on that cycle.
// Slot state lives in one RAM with registered read. An item keeps busy high through a
// dispatch state and, for each slot visited, a read state and an evaluate state. Slots visited:
// one for reference, pin, unpin and release, lowest free slot + 1 for an
// allocation into a free slot, and from 1 to 3*FRAMES for a clock scan; unknown
// commands and out-of-range slots visit none. After reset the block clears every
// RAM slot with busy high before it takes its first item.
module clock_frame_replacement_core #(
    parameter int FRAMES    = 16,
    parameter int TAG_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cfr_pkg::CMD_W-1:0]   i_cmd,
    input  logic [TAG_WIDTH-1:0]        i_page_tag,
    input  logic                        i_read_only,
    input  logic [cfr_pkg::SLOT_W-1:0]  i_slot,
    input  logic                        i_is_write,
    output logic                        o_done,
    output logic [cfr_pkg::SLOT_W-1:0]  o_frame_slot,
    output logic                        o_evicted,
    output logic [TAG_WIDTH-1:0]        o_evicted_tag,
    output logic                        o_write_back,
    output logic [cfr_pkg::STAT_W-1:0]  o_status
);

    cfr_pkg::t_dp_cmd  ctl;
    cfr_pkg::t_dp_stat stat;

    cfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    cfr_dp #(
        .FRAMES    (FRAMES),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_cmd         (i_cmd),
        .i_page_tag    (i_page_tag),
        .i_read_only   (i_read_only),
        .i_slot        (i_slot),
        .i_is_write    (i_is_write),
        .o_done        (o_done),
        .o_frame_slot  (o_frame_slot),
        .o_evicted     (o_evicted),
        .o_evicted_tag (o_evicted_tag),
        .o_write_back  (o_write_back),
        .o_status      (o_status)
    );

endmodule

// ===== rtl/cfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cfr_dp.sv =====
// Frame table datapath: slot RAM, clock hand, round and fill counters, result registers.
module cfr_dp #(
    parameter int FRAMES    = 16,
    parameter int TAG_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfr_pkg::t_dp_cmd            i_ctl,
    output cfr_pkg::t_dp_stat           o_stat,
    input  logic [cfr_pkg::CMD_W-1:0]   i_cmd,
    input  logic [TAG_WIDTH-1:0]        i_page_tag,
    input  logic                        i_read_only,
    input  logic [cfr_pkg::SLOT_W-1:0]  i_slot,
    input  logic                        i_is_write,
    output logic                        o_done,
    output logic [cfr_pkg::SLOT_W-1:0]  o_frame_slot,
    output logic                        o_evicted,
    output logic [TAG_WIDTH-1:0]        o_evicted_tag,
    output logic                        o_write_back,
    output logic [cfr_pkg::STAT_W-1:0]  o_status
);

    localparam int AW = $clog2(FRAMES);
    localparam int CW = ((AW > cfr_pkg::SLOT_W) ? AW : cfr_pkg::SLOT_W) + 1;
    localparam int NW = $clog2(FRAMES + 1);
    localparam int WW = TAG_WIDTH + cfr_pkg::FLAGS_W;
    localparam logic [AW-1:0] LAST   = AW'(FRAMES - 1);
    localparam logic [1:0]    RLAST  = 2'(cfr_pkg::PASSES - 1);

    logic [cfr_pkg::CMD_W-1:0]  r_cmd;
    logic [TAG_WIDTH-1:0]       r_tag;
    logic                       r_ro;
    logic [cfr_pkg::SLOT_W-1:0] r_slot;
    logic                       r_wr;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              r_hand;
    logic [AW-1:0]              r_start;
    logic [1:0]                 r_round;
    logic [NW-1:0]              r_cnt;

    logic                        r_done;
    logic [cfr_pkg::SLOT_W-1:0]  r_frame_slot;
    logic                        r_evicted;
    logic [TAG_WIDTH-1:0]        r_evicted_tag;
    logic                        r_write_back;
    logic [cfr_pkg::STAT_W-1:0]  r_status;

    logic [cfr_pkg::SLOT_W-1:0]  n_frame_slot;
    logic                        n_evicted;
    logic [TAG_WIDTH-1:0]        n_evicted_tag;
    logic                        n_write_back;
    logic [cfr_pkg::STAT_W-1:0]  n_status;

    logic [WW-1:0]    ram_q;
    logic [WW-1:0]    wdata;
    cfr_pkg::t_flags  q_f;
    cfr_pkg::t_flags  w_f;
    logic [TAG_WIDTH-1:0] q_tag;
    logic [CW-1:0]    slot_ext;
    logic [CW-1:0]    idx_ext;
    logic [AW-1:0]    next_hand;
    logic             suit;

    assign q_f       = ram_q[cfr_pkg::FLAGS_W-1:0];
    assign q_tag     = ram_q[WW-1:cfr_pkg::FLAGS_W];
    assign slot_ext  = CW'(r_slot);
    assign idx_ext   = CW'(r_idx);
    assign next_hand = (r_hand == LAST) ? '0 : r_hand + AW'(1);

    always_comb begin
        if (q_f.pinned) begin
            suit = 1'b0;
        end else if (r_round == 2'd0) begin
            suit = q_f.readonly || (!q_f.accessed && !q_f.dirty);
        end else if (r_round == 2'd1) begin
            suit = q_f.readonly || !q_f.dirty;
        end else begin
            suit = 1'b1;
        end
    end

    always_comb begin
        w_f = q_f;
        unique case (i_ctl.wr_sel)
            cfr_pkg::WR_CLEAR: begin
                w_f   = '0;
                wdata = '0;
            end
            cfr_pkg::WR_FILL: begin
                w_f          = '0;
                w_f.used     = 1'b1;
                w_f.readonly = r_ro;
                wdata        = {r_tag, w_f};
            end
            cfr_pkg::WR_OP: begin
                unique case (r_cmd)
                    cfr_pkg::CMD_REF: begin
                        w_f.accessed = 1'b1;
                        if (r_wr) begin
                            w_f.dirty = 1'b1;
                        end
                    end
                    cfr_pkg::CMD_PIN:     w_f.pinned = 1'b1;
                    cfr_pkg::CMD_UNPIN:   w_f.pinned = 1'b0;
                    cfr_pkg::CMD_RELEASE: w_f = '0;
                    default:              w_f = q_f;
                endcase
                wdata = {q_tag, w_f};
            end
            cfr_pkg::WR_AGE: begin
                w_f.accessed = 1'b0;
                if (q_f.dirty) begin
                    w_f.dirty = 1'b0;
                    w_f.pend  = 1'b1;
                end
                wdata = {q_tag, w_f};
            end
            default: begin
                wdata = '0;
            end
        endcase
    end

    cfr_ram #(
        .WIDTH(WW),
        .DEPTH(FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.ram_wr),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd  <= i_cmd;
            r_tag  <= i_page_tag;
            r_ro   <= i_read_only;
            r_slot <= i_slot;
            r_wr   <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_hand  <= '0;
            r_start <= '0;
            r_round <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            unique case (i_ctl.idx_sel)
                cfr_pkg::IDX_HOLD:      r_idx <= r_idx;
                cfr_pkg::IDX_ZERO:      r_idx <= '0;
                cfr_pkg::IDX_INC:       r_idx <= r_idx + AW'(1);
                cfr_pkg::IDX_SLOT:      r_idx <= slot_ext[AW-1:0];
                cfr_pkg::IDX_HAND:      r_idx <= r_hand;
                cfr_pkg::IDX_NEXT_HAND: r_idx <= next_hand;
                default:                r_idx <= r_idx;
            endcase
            if (i_ctl.scan_init) begin
                r_start <= r_hand;
                r_round <= '0;
            end
            if (i_ctl.hand_adv) begin
                r_hand <= next_hand;
                if (next_hand == r_start) begin
                    r_round <= r_round + 2'd1;
                end
            end
            if (i_ctl.cnt_inc) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_cnt <= r_cnt - NW'(1);
            end
            r_done <= i_ctl.resp;
        end
    end

    always_comb begin
        n_frame_slot  = r_slot;
        n_evicted     = 1'b0;
        n_evicted_tag = '0;
        n_write_back  = 1'b0;
        n_status      = cfr_pkg::STAT_OK;
        unique case (i_ctl.resp_sel)
            cfr_pkg::RESP_OK: begin
                n_status = cfr_pkg::STAT_OK;
            end
            cfr_pkg::RESP_NOUSE: begin
                n_status = cfr_pkg::STAT_NOUSE;
            end
            cfr_pkg::RESP_PINNED: begin
                n_status = cfr_pkg::STAT_PINNED;
            end
            cfr_pkg::RESP_GRANT: begin
                n_frame_slot = idx_ext[cfr_pkg::SLOT_W-1:0];
            end
            cfr_pkg::RESP_EVICT: begin
                n_frame_slot  = idx_ext[cfr_pkg::SLOT_W-1:0];
                n_evicted     = 1'b1;
                n_evicted_tag = q_tag;
                n_write_back  = q_f.dirty || q_f.pend;
            end
            default: begin
                n_status = cfr_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.resp) begin
            r_frame_slot  <= n_frame_slot;
            r_evicted     <= n_evicted;
            r_evicted_tag <= n_evicted_tag;
            r_write_back  <= n_write_back;
            r_status      <= n_status;
        end
    end

    assign o_stat.cmd_alloc   = (r_cmd == cfr_pkg::CMD_ALLOC);
    assign o_stat.cmd_op      = (r_cmd == cfr_pkg::CMD_REF) || (r_cmd == cfr_pkg::CMD_PIN) ||
                                (r_cmd == cfr_pkg::CMD_UNPIN) || (r_cmd == cfr_pkg::CMD_RELEASE);
    assign o_stat.cmd_release = (r_cmd == cfr_pkg::CMD_RELEASE);
    assign o_stat.slot_ok     = (slot_ext < CW'(FRAMES));
    assign o_stat.full        = (r_cnt == NW'(FRAMES));
    assign o_stat.q_used      = q_f.used;
    assign o_stat.suit        = suit;
    assign o_stat.wrap_last   = (next_hand == r_start) && (r_round == RLAST);
    assign o_stat.clear_last  = (r_idx == LAST);

    assign o_done        = r_done;
    assign o_frame_slot  = r_frame_slot;
    assign o_evicted     = r_evicted;
    assign o_evicted_tag = r_evicted_tag;
    assign o_write_back  = r_write_back;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(FRAMES))
        else $error("used slot count above frame count");
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST)
        else $error("clock hand out of range");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.hand_adv |-> r_round <= RLAST)
        else $error("scan ran past its last round");
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.resp && i_ctl.resp_sel == cfr_pkg::RESP_EVICT) |-> o_stat.full)
        else $error("eviction while a free slot exists");
`endif

endmodule

// ===== rtl/cfr_ctrl.sv =====
// Frame table controller: sequences clearing, free search, slot commands and clock scan.
module cfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cfr_pkg::t_dp_stat  i_stat,
    output cfr_pkg::t_dp_cmd   o_ctl
);

    cfr_pkg::t_state r_state;
    cfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_ctl.idx_sel  = cfr_pkg::IDX_HOLD;
        o_ctl.wr_sel   = cfr_pkg::WR_CLEAR;
        o_ctl.resp_sel = cfr_pkg::RESP_OK;
        unique case (r_state)
            cfr_pkg::S_CLEAR: begin
                o_ctl.ram_wr = 1'b1;
                o_ctl.wr_sel = cfr_pkg::WR_CLEAR;
                if (i_stat.clear_last) begin
                    o_ctl.idx_sel = cfr_pkg::IDX_ZERO;
                    n_state       = cfr_pkg::S_IDLE;
                end else begin
                    o_ctl.idx_sel = cfr_pkg::IDX_INC;
                end
            end
            cfr_pkg::S_IDLE: begin
                if (start) begin
                    o_ctl.latch = 1'b1;
                    n_state     = cfr_pkg::S_DISPATCH;
                end
            end
            cfr_pkg::S_DISPATCH: begin
                if (i_stat.cmd_alloc) begin
                    if (!i_stat.full) begin
                        o_ctl.idx_sel = cfr_pkg::IDX_ZERO;
                        n_state       = cfr_pkg::S_FREE_RD;
                    end else begin
                        o_ctl.idx_sel   = cfr_pkg::IDX_HAND;
                        o_ctl.scan_init = 1'b1;
                        n_state         = cfr_pkg::S_SCAN_RD;
                    end
                end else if (i_stat.cmd_op) begin
                    if (i_stat.slot_ok) begin
                        o_ctl.idx_sel = cfr_pkg::IDX_SLOT;
                        n_state       = cfr_pkg::S_OP_RD;
                    end else begin
                        o_ctl.resp     = 1'b1;
                        o_ctl.resp_sel = cfr_pkg::RESP_NOUSE;
                        n_state        = cfr_pkg::S_IDLE;
                    end
                end else begin
                    o_ctl.resp     = 1'b1;
                    o_ctl.resp_sel = cfr_pkg::RESP_OK;
                    n_state        = cfr_pkg::S_IDLE;
                end
            end
            cfr_pkg::S_FREE_RD: begin
                n_state = cfr_pkg::S_FREE_EV;
            end
            cfr_pkg::S_FREE_EV: begin
                if (!i_stat.q_used) begin
                    o_ctl.ram_wr   = 1'b1;
                    o_ctl.wr_sel   = cfr_pkg::WR_FILL;
                    o_ctl.cnt_inc  = 1'b1;
                    o_ctl.resp     = 1'b1;
                    o_ctl.resp_sel = cfr_pkg::RESP_GRANT;
                    n_state        = cfr_pkg::S_IDLE;
                end else begin
                    o_ctl.idx_sel = cfr_pkg::IDX_INC;
                    n_state       = cfr_pkg::S_FREE_RD;
                end
            end
            cfr_pkg::S_OP_RD: begin
                n_state = cfr_pkg::S_OP_EV;
            end
            cfr_pkg::S_OP_EV: begin
                o_ctl.resp = 1'b1;
                n_state    = cfr_pkg::S_IDLE;
                if (i_stat.q_used) begin
                    o_ctl.ram_wr   = 1'b1;
                    o_ctl.wr_sel   = cfr_pkg::WR_OP;
                    o_ctl.cnt_dec  = i_stat.cmd_release;
                    o_ctl.resp_sel = cfr_pkg::RESP_OK;
                end else begin
                    o_ctl.resp_sel = cfr_pkg::RESP_NOUSE;
                end
            end
            cfr_pkg::S_SCAN_RD: begin
                n_state = cfr_pkg::S_SCAN_EV;
            end
            cfr_pkg::S_SCAN_EV: begin
                o_ctl.ram_wr   = 1'b1;
                o_ctl.hand_adv = 1'b1;
                if (i_stat.suit) begin
                    o_ctl.wr_sel   = cfr_pkg::WR_FILL;
                    o_ctl.resp     = 1'b1;
                    o_ctl.resp_sel = cfr_pkg::RESP_EVICT;
                    n_state        = cfr_pkg::S_IDLE;
                end else begin
                    o_ctl.wr_sel = cfr_pkg::WR_AGE;
                    if (i_stat.wrap_last) begin
                        o_ctl.resp     = 1'b1;
                        o_ctl.resp_sel = cfr_pkg::RESP_PINNED;
                        n_state        = cfr_pkg::S_IDLE;
                    end else begin
                        o_ctl.idx_sel = cfr_pkg::IDX_NEXT_HAND;
                        n_state       = cfr_pkg::S_SCAN_RD;
                    end
                end
            end
            default: begin
                n_state = cfr_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != cfr_pkg::S_IDLE);

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == cfr_pkg::S_DISPATCH))
        else $error("accepted item not dispatched");
    a_resp_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.resp |=> !busy)
        else $error("result issued without returning to idle");
    a_scan_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfr_pkg::S_SCAN_EV) |-> ($past(r_state) == cfr_pkg::S_SCAN_RD))
        else $error("scan evaluation without a preceding read");
`endif

endmodule
